@@ hw/rtl/scs_pkg.sv @@
`timescale 1ns / 1ps
package scs_pkg;

  localparam int ENTRY_COUNT_DEF = 256;
  localparam int SKILL_COUNT_DEF = 5;
  localparam int SKILL_MAX       = 5;
  localparam int VAL_W           = 32;
  localparam int IDX_W           = 9;

  // sort modes
  localparam logic [1:0] MODE_AGE   = 2'd0;
  localparam logic [1:0] MODE_SKILL = 2'd1;
  localparam logic [1:0] MODE_HLTH  = 2'd2;

  // commands
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // register byte index bit
  localparam logic REG_SORT_MODE = 1'b0;

  typedef logic [3*VAL_W-1:0] rec_t;  // {health, age, top skill}

  function automatic logic signed [VAL_W-1:0] key_of(input logic [1:0] mode,
                                                      input rec_t rec);
    logic signed [VAL_W-1:0] k;
    case (mode)
      MODE_SKILL: k = rec[VAL_W-1:0];
      MODE_HLTH:  k = rec[3*VAL_W-1:2*VAL_W];
      default:    k = rec[2*VAL_W-1:VAL_W];
    endcase
    return k;
  endfunction

endpackage

@@ hw/rtl/sorted_cursor_stepper.sv @@
`timescale 1ns / 1ps
// Record table with a sorted cursor. A write transfer has an accept state,
// SKILL_COUNT-1 signed compares for the top skill, then the store. A step
// transfer makes one sweep over the record memory that counts the live records
// and the rank of the current selection; when no record is listed it returns
// the fallback after that sweep. Otherwise a radix select over the {key, index}
// value then finds the record at the new cursor, one bit per sweep. Each sweep
// reads the single record memory port once a cycle. A stalled output holds the
// block in its result state until the output register is free.
// in_stall is high for the whole of an item; one finished result may wait
// in the output register while the next item is taken.
module sorted_cursor_stepper #(
  parameter int ENTRY_COUNT = scs_pkg::ENTRY_COUNT_DEF,
  parameter int SKILL_COUNT = scs_pkg::SKILL_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                command,
  input  logic signed [8:0]   record_index,
  input  logic                occupied,
  input  logic signed [31:0]  health,
  input  logic signed [31:0]  age,
  input  logic signed [31:0]  skill_a,
  input  logic signed [31:0]  skill_b,
  input  logic signed [31:0]  skill_c,
  input  logic signed [31:0]  skill_d,
  input  logic signed [31:0]  skill_e,
  input  logic signed [8:0]   fallback_choice,
  input  logic                move_right,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [8:0]   chosen_index,
  output logic [8:0]          listed_total,
  output logic                used_fallback,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int IW = $clog2(ENTRY_COUNT);
  localparam int CW = IW + 1;
  localparam int PW = 32 + IW;
  localparam int LW = IW + 2;
  localparam int SW = 3;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WMAX  = 3'd1;
  localparam logic [2:0] S_RDA   = 3'd2;
  localparam logic [2:0] S_RDB   = 3'd3;
  localparam logic [2:0] S_CNT   = 3'd4;
  localparam logic [2:0] S_DEC   = 3'd5;
  localparam logic [2:0] S_SEL   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state;

  // latched item
  logic signed [8:0]       idx_r;
  logic                    occ_r;
  logic signed [31:0]      hl_r;
  logic signed [31:0]      age_r;
  logic signed [31:0]      sk_r [0:scs_pkg::SKILL_MAX-1];
  logic signed [8:0]       fb_r;
  logic                    up_r;
  logic signed [31:0]      best;
  logic [SW-1:0]           sk_i;

  logic [1:0]              mode;
  logic signed [LW-1:0]    cursor;
  logic signed [LW-1:0]    last;

  // record store
  scs_pkg::rec_t           mem [0:ENTRY_COUNT-1];
  logic [ENTRY_COUNT-1:0]  occ;
  scs_pkg::rec_t           rd_data;
  logic                    rd_occ;
  logic [IW-1:0]           ra;
  logic                    we;

  // sweep
  logic [CW-1:0]           addr;
  logic                    pv;
  logic [IW-1:0]           pj;
  logic [CW-1:0]           n;
  logic [CW-1:0]           rank;
  logic [CW-1:0]           cnt0;
  logic signed [31:0]      kx;
  logic                    live_x;
  logic [CW-1:0]           pt;
  logic [CW-1:0]           pr;
  logic [PW-1:0]           pref;
  logic [PW-1:0]           mask;
  logic [PW-1:0]           bitsel;

  logic [IW-1:0]           xa;
  logic                    in_rng;
  logic                    live;
  logic signed [31:0]      kj;
  logic [PW-1:0]           cj;
  logic                    sweep_end;
  logic                    restart;
  logic [CW-1:0]           base;
  logic                    out_free;
  logic                    out_load;

  assign xa     = IW'(idx_r[7:0]);
  assign in_rng = !idx_r[8] && (32'(idx_r) < ENTRY_COUNT);
  assign ra     = (state == S_IDLE || state == S_WMAX || state == S_RDA) ? xa
                                                                      : addr[IW-1:0];
  assign we     = (state == S_WMAX) && (32'(sk_i) >= SKILL_COUNT) && in_rng;
  assign live   = pv && rd_occ && ($signed(rd_data[95:64]) > 0);
  assign kj     = scs_pkg::key_of(mode, rd_data);
  assign cj     = {kj[31] ^ 1'b1, kj[30:0], pj};
  assign sweep_end = (addr == CW'(ENTRY_COUNT)) && !pv;
  assign restart = (32'(idx_r) != 32'(last)) || cursor[LW-1] ||
                   (CW'(cursor[LW-2:0]) >= n);
  assign out_free = !out_valid || !out_stall;
  assign out_load = out_free && ((state == S_DEC && n == '0) || state == S_DONE);

  always_comb begin
    if (restart) begin
      if (live_x) begin
        base = rank;
      end else if (up_r) begin
        base = n - CW'(1);
      end else begin
        base = '0;
      end
    end else begin
      base = CW'(cursor[LW-2:0]);
    end
  end

  assign in_stall = (state != S_IDLE);
  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == scs_pkg::REG_SORT_MODE) ? {30'b0, mode} : 32'b0;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[xa] <= {hl_r, age_r, best};
    end
    rd_data <= mem[ra];
    rd_occ  <= occ[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occ       <= '0;
      mode      <= scs_pkg::MODE_AGE;
      cursor    <= '1;
      last      <= '1;
      out_valid <= 1'b0;
      pv        <= 1'b0;
    end else begin
      if (psel && penable && pwrite && paddr[2] == scs_pkg::REG_SORT_MODE) begin
        mode <= pwdata[1:0];
      end
      if (out_valid && !out_stall && !out_load) begin
        out_valid <= 1'b0;
      end
      // read pipeline for sweeps
      pv <= (state == S_CNT || state == S_SEL) && (addr != CW'(ENTRY_COUNT));
      pj <= addr[IW-1:0];
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            idx_r    <= record_index;
            occ_r    <= occupied;
            hl_r     <= health;
            age_r    <= age;
            sk_r[0]  <= skill_a;
            sk_r[1]  <= skill_b;
            sk_r[2]  <= skill_c;
            sk_r[3]  <= skill_d;
            sk_r[4]  <= skill_e;
            best     <= skill_a;
            sk_i     <= SW'(1);
            fb_r     <= fallback_choice;
            up_r     <= move_right;
            state    <= (command == scs_pkg::CMD_WRITE) ? S_WMAX : S_RDA;
          end
        end
        S_WMAX: begin
          if (32'(sk_i) < SKILL_COUNT) begin
            if (sk_r[sk_i] > best) begin
              best <= sk_r[sk_i];
            end
            sk_i <= sk_i + SW'(1);
          end else begin
            if (in_rng) begin
              occ[xa] <= occ_r;
            end
            state <= S_IDLE;
          end
        end
        S_RDA: begin
          state <= S_RDB;
        end
        S_RDB: begin
          kx     <= scs_pkg::key_of(mode, rd_data);
          live_x <= in_rng && rd_occ && ($signed(rd_data[95:64]) > 0);
          addr   <= '0;
          n      <= '0;
          rank   <= '0;
          state  <= S_CNT;
        end
        S_CNT: begin
          if (addr != CW'(ENTRY_COUNT)) begin
            addr <= addr + CW'(1);
          end
          if (live) begin
            n <= n + CW'(1);
            if (live_x && (kj < kx || (kj == kx && pj < xa))) begin
              rank <= rank + CW'(1);
            end
          end
          if (sweep_end) begin
            state <= S_DEC;
          end
        end
        S_DEC: begin
          if (n == '0) begin
            if (out_free) begin
              chosen_index  <= fb_r;
              listed_total  <= '0;
              used_fallback <= 1'b1;
              out_valid     <= 1'b1;
              state         <= S_IDLE;
            end
          end else begin
            if (up_r) begin
              pt <= (base == n - CW'(1)) ? '0 : base + CW'(1);
              pr <= (base == n - CW'(1)) ? '0 : base + CW'(1);
            end else begin
              pt <= (base == '0) ? n - CW'(1) : base - CW'(1);
              pr <= (base == '0) ? n - CW'(1) : base - CW'(1);
            end
            pref   <= '0;
            mask   <= '0;
            bitsel <= {1'b1, {(PW-1){1'b0}}};
            addr   <= '0;
            cnt0   <= '0;
            state  <= S_SEL;
          end
        end
        S_SEL: begin
          // one radix bit per sweep: count live candidates with this bit clear
          if (addr != CW'(ENTRY_COUNT)) begin
            addr <= addr + CW'(1);
          end
          if (live && (((cj ^ pref) & mask) == '0) && ((cj & bitsel) == '0)) begin
            cnt0 <= cnt0 + CW'(1);
          end
          if (sweep_end) begin
            if (pr >= cnt0) begin
              pref <= pref | bitsel;
              pr   <= pr - cnt0;
            end
            mask   <= mask | bitsel;
            bitsel <= bitsel >> 1;
            addr   <= '0;
            cnt0   <= '0;
            if (bitsel[0]) begin
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            chosen_index  <= 9'(pref[IW-1:0]);
            listed_total  <= 9'(n);
            used_fallback <= 1'b0;
            out_valid     <= 1'b1;
            cursor        <= LW'(pt);
            last          <= LW'(pref[IW-1:0]);
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_fb_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && used_fallback |-> listed_total == 9'd0)
    else $error("fallback result with nonzero total");

  a_total_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && !used_fallback |-> listed_total != 9'd0)
    else $error("listed result with zero total");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("transfer accepted without going busy");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    $past(out_valid) && $past(out_stall) |-> out_valid && $stable(chosen_index))
    else $error("stalled result changed");

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
module tb;

  localparam int NREC = 256;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 60000;

  typedef struct {
    logic cmd;
    logic signed [8:0] idx;
    logic occ;
    logic signed [31:0] hp, ag, sa, sb, sc, sd, se;
    logic signed [8:0] fb;
    logic up;
  } item_t;

  typedef struct {
    logic signed [8:0] chosen;
    logic [8:0] total;
    logic fell_back;
  } pick_t;

  typedef struct {
    item_t it;
    bit typed;
    pick_t want;
  } row_t;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  logic command, occupied, move_right, used_fallback;
  logic signed [8:0] record_index, fallback_choice, chosen_index;
  logic signed [31:0] health, age, skill_a, skill_b, skill_c, skill_d, skill_e;
  logic [8:0] listed_total;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  sorted_cursor_stepper uut (.*);

  // predictor copy of the block state
  logic rec_occ[NREC];
  logic signed [31:0] rec_hp[NREC], rec_age[NREC], rec_skill[NREC];
  int cursor, handed_out;
  logic [1:0] mode;

  pick_t pending_picks[$];
  int mismatches;
  int idle_cycles;
  bit quiet, timed_out;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [31:0] sort_key(int i);
    if (mode == scs_pkg::MODE_SKILL) return rec_skill[i];
    if (mode == scs_pkg::MODE_HLTH) return rec_hp[i];
    return rec_age[i];
  endfunction

  // returns 1 when the item yields a pick
  function automatic bit predict_pick(item_t it, output pick_t p);
    int order[NREC];
    logic signed [31:0] keys[NREC];
    int n, j, pos;
    logic signed [31:0] k, best;
    n = 0;
    if (it.cmd == scs_pkg::CMD_WRITE) begin
      if (it.idx < 0) return 0;
      best = it.sa;
      if (it.sb > best) best = it.sb;
      if (it.sc > best) best = it.sc;
      if (it.sd > best) best = it.sd;
      if (it.se > best) best = it.se;
      rec_occ[it.idx] = it.occ;
      rec_hp[it.idx] = it.hp;
      rec_age[it.idx] = it.ag;
      rec_skill[it.idx] = best;
      return 0;
    end
    for (int i = 0; i < NREC; i++) begin
      if (!rec_occ[i] || rec_hp[i] <= 0) continue;
      k = sort_key(i);
      j = n;
      while (j > 0 && keys[j-1] > k) begin
        keys[j] = keys[j-1];
        order[j] = order[j-1];
        j--;
      end
      keys[j] = k;
      order[j] = i;
      n++;
    end
    if (n == 0) begin
      p.chosen = it.fb;
      p.total = 0;
      p.fell_back = 1;
      return 1;
    end
    if (int'(it.idx) != handed_out || cursor < 0 || cursor >= n) begin
      pos = -1;
      for (int q = 0; q < n; q++)
        if (pos < 0 && order[q] == int'(it.idx)) pos = q;
      if (pos < 0) pos = it.up ? n - 1 : 0;
    end else begin
      pos = cursor;
    end
    pos = (pos + (it.up ? 1 : n - 1)) % n;
    cursor = pos;
    handed_out = order[pos];
    p.chosen = handed_out;
    p.total = n;
    p.fell_back = 0;
    return 1;
  endfunction

  function automatic item_t wr(int idx, bit occ, int hp, int ag,
                               int sa, int sb, int sc, int sd, int se);
    item_t it;
    it = '{cmd: scs_pkg::CMD_WRITE, idx: idx, occ: occ, hp: hp, ag: ag, sa: sa,
           sb: sb, sc: sc, sd: sd, se: se, fb: 0, up: 0};
    return it;
  endfunction

  function automatic item_t st(int idx, int fb, bit up);
    item_t it;
    it = '{cmd: scs_pkg::CMD_STEP, idx: idx, occ: 0, hp: 0, ag: 0, sa: 0, sb: 0,
           sc: 0, sd: 0, se: 0, fb: fb, up: up};
    return it;
  endfunction

  // valid stays up until the next item or idle cycle replaces it
  task automatic send(item_t it, bit typed, pick_t want);
    pick_t p;
    while (!quiet && $urandom_range(99) < 31) begin
      in_valid <= 0;
      @(negedge clk);
    end
    command <= it.cmd; record_index <= it.idx; occupied <= it.occ;
    health <= it.hp; age <= it.ag; skill_a <= it.sa; skill_b <= it.sb;
    skill_c <= it.sc; skill_d <= it.sd; skill_e <= it.se;
    fallback_choice <= it.fb; move_right <= it.up;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    if (predict_pick(it, p)) pending_picks.push_back(typed ? want : p);
    @(negedge clk);
  endtask

  task automatic set_mode(logic [1:0] m);
    in_valid <= 0;
    while (pending_picks.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    psel <= 1; pwrite <= 1; paddr <= {scs_pkg::REG_SORT_MODE, 2'b00};
    pwdata <= m; penable <= 0;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    mode = m;
  endtask

  function automatic logic signed [31:0] rand_val();
    if ($urandom_range(3) == 0) return $urandom;
    return $signed($urandom_range(60)) - 10;
  endfunction

  function automatic item_t rand_item();
    item_t it;
    int idx;
    if ($urandom_range(99) < 45) begin
      idx = ($urandom_range(9) == 0) ? $urandom_range(256) - 1 : $urandom_range(15);
      it = wr(idx, $urandom_range(99) < 80, rand_val(), rand_val(),
              $urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      // mostly follow the last pick, as a user pressing repeatedly would
      idx = ($urandom_range(99) < 70) ? handed_out : $urandom_range(256) - 1;
      it = st(idx, $urandom_range(256) - 1, $urandom_range(1));
    end
    return it;
  endfunction

  always @(negedge clk)
    out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 31);

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_picks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pick transfer: %0d", chosen_index);
      end else begin
        if (chosen_index !== pending_picks[0].chosen ||
            listed_total !== pending_picks[0].total ||
            used_fallback !== pending_picks[0].fell_back) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pick mismatch: exp %0d/%0d/%0b got %0d/%0d/%0b",
                     pending_picks[0].chosen, pending_picks[0].total,
                     pending_picks[0].fell_back, chosen_index, listed_total,
                     used_fallback);
        end
        void'(pending_picks.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT && !timed_out) begin
      timed_out = 1;
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    pick_t none;
    none = '{chosen: 0, total: 0, fell_back: 0};
    rst = 1; in_valid = 0; out_stall = 0; quiet = 0; timed_out = 0;
    command = 0; record_index = 0; occupied = 0; health = 0; age = 0;
    skill_a = 0; skill_b = 0; skill_c = 0; skill_d = 0; skill_e = 0;
    fallback_choice = 0; move_right = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    mismatches = 0; idle_cycles = 0;
    for (int i = 0; i < NREC; i++) begin
      rec_occ[i] = 0; rec_hp[i] = 0; rec_age[i] = 0; rec_skill[i] = 0;
    end
    cursor = -1; handed_out = -1; mode = scs_pkg::MODE_AGE;

    // empty table: fallback comes straight back
    rows.push_back('{st(-1, 255, 1), 1, '{chosen: 255, total: 0, fell_back: 1}});
    rows.push_back('{st(3, -1, 0), 1, '{chosen: -1, total: 0, fell_back: 1}});
    rows.push_back('{wr(-1, 1, 5, 5, 1, 1, 1, 1, 1), 0, none});
    rows.push_back('{st(0, 0, 1), 1, '{chosen: 0, total: 0, fell_back: 1}});
    rows.push_back('{wr(0, 1, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
                        -1, 0, 1), 0, none});
    rows.push_back('{wr(255, 1, 1, 32'h7fffffff, -5, -4, -3, -2, -1), 0, none});
    rows.push_back('{wr(7, 1, 0, 3, 9, 9, 9, 9, 9), 0, none});
    rows.push_back('{wr(8, 1, 32'h80000000, 3, 2, 2, 2, 2, 2), 0, none});
    rows.push_back('{wr(9, 0, 50, 3, 1, 2, 3, 4, 5), 0, none});
    rows.push_back('{wr(10, 1, 20, 7, 1, 2, 3, 4, 32'h55aa55aa), 0, none});
    rows.push_back('{wr(11, 1, 20, 7, 32'haa55aa55, 2, 3, 4, 5), 0, none});
    rows.push_back('{st(-1, 4, 1), 0, none});
    rows.push_back('{st(-1, 4, 0), 0, none});
    rows.push_back('{st(9, 4, 1), 0, none});
    rows.push_back('{st(10, 0, 1), 0, none});
    rows.push_back('{st(0, 0, 0), 0, none});
    rows.push_back('{st(255, 0, 1), 0, none});
    rows.push_back('{st(255, 0, 1), 0, none});
    rows.push_back('{wr(0, 0, 1, 1, 1, 1, 1, 1, 1), 0, none});
    rows.push_back('{st(255, 0, 0), 0, none});

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    foreach (rows[r]) send(rows[r].it, rows[r].typed, rows[r].want);

    // one phase per setting, including the unused mode; one phase without idling
    for (int ph = 0; ph < 4; ph++) begin
      set_mode(ph == 0 ? scs_pkg::MODE_SKILL : ph == 1 ? scs_pkg::MODE_HLTH :
               ph == 2 ? MODE_UNUSED : scs_pkg::MODE_AGE);
      quiet = (ph == 2);
      repeat (30) send(rand_item(), 0, none);
    end
    quiet = 0;
    in_valid <= 0;

    while (pending_picks.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
